>>> hdl/ldh_pkg.sv
// ----------------------------------------------------------------------------
// ldh_pkg: shared types and constants for the decompose / hint unit
// Word widths, request codes, configuration indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ldh_pkg;

  localparam int DW         = 32;
  localparam int COEFF_BITS = 32;

  // coefficients are cut to COEFF_BITS before reduction
  localparam logic [DW-1:0] COEFF_MASK =
    (COEFF_BITS >= DW) ? {DW{1'b1}} : DW'((64'd1 << COEFF_BITS) - 64'd1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_Q  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HINT_M     = 2'd2;

  localparam logic [DW-1:0] RST_MODULUS_Q = 32'd8380417;
  localparam logic [DW-1:0] RST_GAMMA     = 32'd523776;
  localparam logic [DW-1:0] RST_HINT_M    = 32'd16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [DW-1:0] word_t;

  typedef enum logic [1:0] {
    REQ_DECOMPOSE = 2'd0,
    REQ_MAKE_HINT = 2'd1,
    REQ_USE_HINT  = 2'd2
  } req_t;

  // effective configuration with derived bounds
  typedef struct packed {
    word_t q;
    word_t q_m1;
    word_t q_half;
    word_t g;
    word_t g_half;
    word_t m;
    word_t m_half;
  } cfg_t;

  // request after reduction mod q
  typedef struct packed {
    req_t  req;
    word_t r;
    word_t o;
  } item_t;

endpackage

`default_nettype wire

>>> hdl/ldh_if.sv
// ----------------------------------------------------------------------------
// ldh_if: channel interfaces of the decompose / hint unit
// Request, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldh_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  ldh_pkg::word_t      coeff_r;
  ldh_pkg::word_t      coeff_other;

  modport source (output valid, req_type, coeff_r, coeff_other, input ready);
  modport sink   (input valid, req_type, coeff_r, coeff_other, output ready);
endinterface

interface ldh_out_if;
  logic                valid;
  logic                ready;
  ldh_pkg::word_t      high_part;
  ldh_pkg::word_t      low_part;

  modport source (output valid, high_part, low_part, input ready);
  modport sink   (input valid, high_part, low_part, output ready);
endinterface

interface ldh_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ldh_pkg::CFG_IDX_W-1:0]      index;
  ldh_pkg::word_t                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/ldh_udiv.sv
// ----------------------------------------------------------------------------
// ldh_udiv: pipelined restoring divider
// One quotient bit per stage, DW stages after the load stage; whole pipe
// advances on en.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_udiv (
  input  logic           clk,
  input  logic           en,
  input  ldh_pkg::word_t num,
  input  ldh_pkg::word_t den,
  output ldh_pkg::word_t quot,
  output ldh_pkg::word_t rem
);
  import ldh_pkg::*;

  word_t       n_r   [DW+1];
  word_t       p_r   [DW+1];
  word_t       n_nxt [DW+1];
  word_t       p_nxt [DW+1];
  logic [DW:0] trial;
  logic        ge;

  always_comb begin
    trial    = '0;
    ge       = 1'b0;
    n_nxt[0] = num;
    p_nxt[0] = '0;
    for (int k = 1; k <= DW; k++) begin
      trial    = {p_r[k-1], n_r[k-1][DW-1]};
      ge       = (trial >= {1'b0, den});
      p_nxt[k] = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      n_nxt[k] = {n_r[k-1][DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= DW; k++) begin
        n_r[k] <= n_nxt[k];
        p_r[k] <= p_nxt[k];
      end
    end
  end

  assign quot = n_r[DW];
  assign rem  = p_r[DW];

endmodule

`default_nettype wire

>>> hdl/ldh_front.sv
// ----------------------------------------------------------------------------
// ldh_front: request intake and reduction mod q
// Takes request transactions, reduces both coefficients mod q and pushes
// the reduced request into the queue. Freezes while the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_front (
  input  logic            clk,
  input  logic            rst_n,
  input  ldh_pkg::cfg_t   cfg,
  ldh_in_if.sink          in_chan,
  input  logic            q_full,
  output logic            push,
  output ldh_pkg::item_t  push_item
);
  import ldh_pkg::*;

  logic        en;
  logic [DW:0] vld_r;
  req_t        req_r [DW+1];
  word_t       r_quot, r_rem;
  word_t       o_quot, o_rem;

  assign en            = !q_full;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DW-1:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r[0] <= req_t'(in_chan.req_type);
      for (int k = 1; k <= DW; k++) req_r[k] <= req_r[k-1];
    end
  end

  ldh_udiv u_div_r (
    .clk  (clk),
    .en   (en),
    .num  (in_chan.coeff_r & COEFF_MASK),
    .den  (cfg.q),
    .quot (r_quot),
    .rem  (r_rem)
  );

  ldh_udiv u_div_o (
    .clk  (clk),
    .en   (en),
    .num  (in_chan.coeff_other & COEFF_MASK),
    .den  (cfg.q),
    .quot (o_quot),
    .rem  (o_rem)
  );

  // quotients of the reduction are not needed
  logic unused_quot;
  assign unused_quot = ^{r_quot, o_quot};

  assign push      = en && vld_r[DW] && !unused_quot | (en && vld_r[DW] && unused_quot);
  assign push_item = '{req: req_r[DW], r: r_rem, o: o_rem};

endmodule

`default_nettype wire

>>> hdl/ldh_fifo.sv
// ----------------------------------------------------------------------------
// ldh_fifo: short queue between front and back
// Small register queue; full and non-empty flags come from a registered count.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ldh_pkg::item_t  push_item,
  input  logic            pop,
  output ldh_pkg::item_t  pop_item,
  output logic            full,
  output logic            nonempty
);
  import ldh_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign pop_item = mem_r[rd_ptr_r];
  assign full     = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign nonempty = (count_r != '0);

endmodule

`default_nettype wire

>>> hdl/ldh_back.sv
// ----------------------------------------------------------------------------
// ldh_back: decomposition, hint arithmetic and result register
// Two lanes divide by gamma (r and (r+o) mod q), finish the decomposition,
// form the hint value, reduce it mod m and drive the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ldh_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  ldh_pkg::item_t  q_item,
  output logic            q_pop,
  ldh_out_if.source       out_chan
);
  import ldh_pkg::*;

  typedef logic signed [DW+1:0] swide_t;
  typedef struct packed {
    req_t  req;
    word_t r;
    word_t a2;
    word_t o;
  } sa_t;
  typedef struct packed {
    req_t  req;
    logic  neg;
    word_t h1;
    word_t lo1;
  } sb_t;

  logic        ben;
  logic [DW:0] sum_ro;
  word_t       a2;
  word_t       quot [2];
  word_t       rem  [2];

  // divide-by-gamma segment
  logic [DW:0] va_r;
  sa_t         sa_r [DW+1];

  // decomposition finish
  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  req_t        req1_r, req2_r, req3_r, req4_r, req5_r;
  word_t       o1_r, o2_r, o3_r, o4_r;
  word_t       a1_r  [2];
  swide_t      r01_r [2];
  logic [DW:0] r11_r [2];
  swide_t      r02_r [2];
  logic [DW:0] r12_r [2];
  swide_t      diff2_r [2];
  word_t       hi3_r [2];
  swide_t      lo3_r;
  word_t       hi4_r [2];
  word_t       lo4_r;

  // hint value
  word_t       h1_5_r, lo1_5_r, hd5_r, vm5_r;
  logic [DW:0] v_sum;
  logic        neg6;
  word_t       mag6;
  logic        adj [2];

  // mod m segment
  logic [DW:0] vb_r;
  sb_t         sb_r [DW+1];
  word_t       m_quot, m_rem;
  logic        v7_r, v8_r;
  sb_t         sb7_r, sb8_r;
  word_t       t7_r, t8_r;
  swide_t      s8_r;

  logic        out_valid_r;
  word_t       high_r, low_r;

  assign ben   = !out_valid_r || out_chan.ready;
  assign q_pop = ben && q_valid;

  assign sum_ro = {1'b0, q_item.r} + {1'b0, q_item.o};
  assign a2     = (sum_ro >= {1'b0, cfg.q}) ? DW'(sum_ro - {1'b0, cfg.q}) : sum_ro[DW-1:0];

  ldh_udiv u_div_g0 (
    .clk (clk), .en (ben), .num (q_item.r), .den (cfg.g), .quot (quot[0]), .rem (rem[0])
  );

  ldh_udiv u_div_g1 (
    .clk (clk), .en (ben), .num (a2), .den (cfg.g), .quot (quot[1]), .rem (rem[1])
  );

  always_comb begin
    for (int k = 0; k < 2; k++) adj[k] = (rem[k] > cfg.g_half);
  end

  // hint centred about q/2, or the use-hint sum; magnitude goes to the mod m divider
  always_comb begin
    neg6 = 1'b0;
    mag6 = vm5_r;
    if (req5_r == REQ_MAKE_HINT) begin
      neg6 = (hd5_r > cfg.q_half);
      mag6 = neg6 ? (cfg.q - hd5_r) : hd5_r;
    end
  end

  assign v_sum = {1'b0, hi4_r[0]} + {1'b0, o4_r};

  ldh_udiv u_div_m (
    .clk (clk), .en (ben), .num (mag6), .den (cfg.m), .quot (m_quot), .rem (m_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      vb_r        <= '0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ben) begin
      va_r        <= {va_r[DW-1:0], q_valid};
      v1_r        <= va_r[DW];
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      vb_r        <= {vb_r[DW-1:0], v5_r};
      v7_r        <= vb_r[DW];
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      sa_r[0] <= '{req: q_item.req, r: q_item.r, a2: a2, o: q_item.o};
      for (int k = 1; k <= DW; k++) sa_r[k] <= sa_r[k-1];

      // centred remainder and high part before the wrap-around case
      req1_r <= sa_r[DW].req;
      o1_r   <= sa_r[DW].o;
      a1_r[0] <= sa_r[DW].r;
      a1_r[1] <= sa_r[DW].a2;
      for (int k = 0; k < 2; k++) begin
        r01_r[k] <= adj[k] ? $signed({2'b00, rem[k]}) - $signed({2'b00, cfg.g})
                           : $signed({2'b00, rem[k]});
        r11_r[k] <= {1'b0, quot[k]} + {{DW{1'b0}}, adj[k]};
      end

      req2_r <= req1_r;
      o2_r   <= o1_r;
      for (int k = 0; k < 2; k++) begin
        diff2_r[k] <= $signed({2'b00, a1_r[k]}) - r01_r[k];
        r02_r[k]   <= r01_r[k];
        r12_r[k]   <= r11_r[k];
      end

      // a - r0 at q-1 folds the high part to zero
      req3_r <= req2_r;
      o3_r   <= o2_r;
      for (int k = 0; k < 2; k++) begin
        if (diff2_r[k] == $signed({2'b00, cfg.q_m1})) begin
          hi3_r[k] <= '0;
        end else if (r12_r[k] >= {1'b0, cfg.q}) begin
          hi3_r[k] <= DW'(r12_r[k] - {1'b0, cfg.q});
        end else begin
          hi3_r[k] <= r12_r[k][DW-1:0];
        end
      end
      lo3_r <= (diff2_r[0] == $signed({2'b00, cfg.q_m1})) ? r02_r[0] - swide_t'(1) : r02_r[0];

      req4_r <= req3_r;
      o4_r   <= o3_r;
      hi4_r  <= hi3_r;
      lo4_r  <= lo3_r[DW+1] ? DW'(lo3_r + $signed({2'b00, cfg.q})) : lo3_r[DW-1:0];

      req5_r  <= req4_r;
      h1_5_r  <= hi4_r[0];
      lo1_5_r <= lo4_r;
      hd5_r   <= hi4_r[1] - hi4_r[0] + ((hi4_r[1] < hi4_r[0]) ? cfg.q : '0);
      vm5_r   <= (v_sum >= {1'b0, cfg.q}) ? DW'(v_sum - {1'b0, cfg.q}) : v_sum[DW-1:0];

      sb_r[0] <= '{req: req5_r, neg: neg6, h1: h1_5_r, lo1: lo1_5_r};
      for (int k = 1; k <= DW; k++) sb_r[k] <= sb_r[k-1];

      sb7_r <= sb_r[DW];
      t7_r  <= (sb_r[DW].neg && m_rem != '0) ? cfg.m - m_rem : m_rem;

      sb8_r <= sb7_r;
      t8_r  <= t7_r;
      s8_r  <= (t7_r > cfg.m_half) ? $signed({2'b00, t7_r}) - $signed({2'b00, cfg.m})
                                   : $signed({2'b00, t7_r});

      case (sb8_r.req)
        REQ_DECOMPOSE: begin
          high_r <= sb8_r.h1;
          low_r  <= sb8_r.lo1;
        end
        REQ_MAKE_HINT: begin
          high_r <= s8_r[DW+1] ? DW'(s8_r + $signed({2'b00, cfg.q})) : s8_r[DW-1:0];
          low_r  <= '0;
        end
        REQ_USE_HINT: begin
          high_r <= t8_r;
          low_r  <= '0;
        end
        default: begin
          high_r <= '0;
          low_r  <= '0;
        end
      endcase
    end
  end

  logic unused_mq;
  assign unused_mq = ^m_quot;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.high_part = high_r;
  assign out_chan.low_part  = low_r ^ {DW{unused_mq & 1'b0}};

endmodule

`default_nettype wire

>>> hdl/lattice_decompose_hint_unit.sv
// ----------------------------------------------------------------------------
// lattice_decompose_hint_unit: coefficient decomposition and hint unit
// Channels: in_chan takes one request (req_type, coeff_r, coeff_other) per
// transaction, out_chan returns one result (high_part, low_part) per
// request, in order. cfg_chan writes modulus_q, gamma and hint_modulus_m;
// it is always ready. The user must write it only while the unit is idle;
// the unit does not enforce this. Throughput: one transaction per cycle
// on both channels while out_chan is ready. The path runs through three
// 32-stage restoring divider pipelines in series: mod q in the front,
// by gamma in the back, then mod m for the hint.
// Stalls: when out_chan is not taken the back part freezes, the 4-entry
// queue fills and then in_chan ready drops; ready comes from a registered
// count, so no combinational path runs from out ready to in ready.
// Reset (rst_n low, synchronous) empties the pipeline and queue and loads
// q = 8380417, gamma = 523776, m = 16. q below two acts as 2, zero gamma
// and zero m as 1. Request code 3 returns zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_decompose_hint_unit (
  input  logic      clk,
  input  logic      rst_n,
  ldh_in_if.sink    in_chan,
  ldh_out_if.source out_chan,
  ldh_cfg_if.sink   cfg_chan
);
  import ldh_pkg::*;

  word_t  q_raw_r, g_raw_r, m_raw_r;
  cfg_t   cfg_r, cfg_nxt;
  word_t  q_eff, g_eff, m_eff;
  logic   q_push, q_pop, q_full, q_nonempty;
  item_t  push_item, pop_item;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_raw_r <= RST_MODULUS_Q;
      g_raw_r <= RST_GAMMA;
      m_raw_r <= RST_HINT_M;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_MODULUS_Q: q_raw_r <= cfg_chan.data;
        CFG_GAMMA:     g_raw_r <= cfg_chan.data;
        CFG_HINT_M:    m_raw_r <= cfg_chan.data;
        default:       ;
      endcase
    end
  end

  always_comb begin
    q_eff          = (q_raw_r < word_t'(2)) ? word_t'(2) : q_raw_r;
    g_eff          = (g_raw_r == '0) ? word_t'(1) : g_raw_r;
    m_eff          = (m_raw_r == '0) ? word_t'(1) : m_raw_r;
    cfg_nxt.q      = q_eff;
    cfg_nxt.q_m1   = q_eff - word_t'(1);
    cfg_nxt.q_half = q_eff >> 1;
    cfg_nxt.g      = g_eff;
    cfg_nxt.g_half = g_eff >> 1;
    cfg_nxt.m      = m_eff;
    cfg_nxt.m_half = m_eff >> 1;
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  ldh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (push_item)
  );

  ldh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .nonempty  (q_nonempty)
  );

  ldh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_nonempty),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty)
    else $error("queue read while empty");

  a_cfg_sane: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cfg_r.q >= word_t'(2) && cfg_r.g != '0 && cfg_r.m != '0))
    else $error("effective configuration out of range");

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for lattice_decompose_hint_unit
// Streams decompose, make-hint and use-hint requests through the unit under
// several modulus / gamma / hint-modulus settings, with bursty input, random
// output stalls and two long output hold-offs, and compares every result
// against a behavioural predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ldh_pkg::*;

  logic clk;
  logic rst_n;

  ldh_in_if  in_chan ();
  ldh_out_if out_chan ();
  ldh_cfg_if cfg_chan ();

  lattice_decompose_hint_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  int n_errors;
  int n_checked;
  int n_sent;
  int hold_off;   // receiver hold-off request, in cycles

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  typedef struct {
    word_t hi;
    word_t lo;
  } coeff_pair_t;

  class hint_scoreboard;
    longint unsigned q_reg, g_reg, m_reg;
    coeff_pair_t expected_q[$];

    function new();
      q_reg = RST_MODULUS_Q;
      g_reg = RST_GAMMA;
      m_reg = RST_HINT_M;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
      case (idx)
        CFG_MODULUS_Q: q_reg = val;
        CFG_GAMMA:     g_reg = val;
        CFG_HINT_M:    m_reg = val;
        default: ;
      endcase
    endfunction

    function longint unsigned floor_mod(longint x, longint unsigned n);
      longint r;
      r = x % longint'(n);
      if (r < 0) r += longint'(n);
      return r;
    endfunction

    function void split_coeff(longint unsigned a, output longint unsigned hi,
                              output longint unsigned lo);
      longint unsigned q, g;
      longint r0, diff, r1;
      q = (q_reg < 2) ? 2 : q_reg;
      g = (g_reg == 0) ? 1 : g_reg;
      r0 = longint'(a % g);
      if (r0 > longint'(g >> 1)) r0 -= longint'(g);
      diff = longint'(a) - r0;
      if (diff == longint'(q - 1)) begin
        r1 = 0;
        r0 -= 1;
      end else begin
        r1 = diff / longint'(g);
      end
      hi = floor_mod(r1, q);
      lo = floor_mod(r0, q);
    endfunction

    function void note_request(logic [1:0] req, word_t cr, word_t co);
      longint unsigned q, m, r, o, h1, h2, lo_d, h, t, hi, lo;
      longint s;
      coeff_pair_t e;
      q = (q_reg < 2) ? 2 : q_reg;
      m = (m_reg == 0) ? 1 : m_reg;
      r = longint'(cr & COEFF_MASK) % q;
      o = longint'(co & COEFF_MASK) % q;
      hi = 0;
      lo = 0;
      case (req)
        REQ_DECOMPOSE: split_coeff(r, hi, lo);
        REQ_MAKE_HINT: begin
          split_coeff(r, h1, lo_d);
          split_coeff((r + o) % q, h2, lo_d);
          h = (h2 + q - h1) % q;
          s = longint'(h);
          if (h > (q >> 1)) s -= longint'(q);
          t = floor_mod(s, m);
          s = longint'(t);
          if (t > (m >> 1)) s -= longint'(m);
          hi = floor_mod(s, q);
        end
        REQ_USE_HINT: begin
          split_coeff(r, h1, lo_d);
          hi = (((h1 + o) % q) % m) % q;
        end
        default: ;
      endcase
      e.hi = word_t'(hi);
      e.lo = word_t'(lo);
      expected_q.push_back(e);
    endfunction

    task check_result(word_t hi, word_t lo);
      coeff_pair_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result hi=%0h lo=%0h", hi, lo));
        return;
      end
      e = expected_q.pop_front();
      if (hi !== e.hi) report($sformatf("high_part %0h, expected %0h", hi, e.hi));
      if (lo !== e.lo) report($sformatf("low_part %0h, expected %0h", lo, e.lo));
    endtask
  endclass

  hint_scoreboard sb;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #4000000;
    $display("FAIL lattice_decompose_hint_unit");
    $finish;
  end

  // result side: stall pattern picked at random from four modes, plus hold-off
  initial begin : receiver
    int mode;
    int cyc;
    out_chan.ready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      if (hold_off > 0) begin
        out_chan.ready = 1'b0;
        hold_off--;
      end else begin
        case (mode)
          0: out_chan.ready = 1'b1;
          1: out_chan.ready = 1'($urandom_range(0, 1));
          2: out_chan.ready = ($urandom_range(0, 7) != 0);
          default: out_chan.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_result(out_chan.high_part, out_chan.low_part);
      n_checked++;
    end
  end

  task automatic send_request(input logic [1:0] req, input word_t cr, input word_t co);
    @(negedge clk);
    in_chan.valid       = 1'b1;
    in_chan.req_type    = req;
    in_chan.coeff_r     = cr;
    in_chan.coeff_other = co;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(req, cr, co);
    n_sent++;
  endtask

  task automatic idle_input(input int n);
    @(negedge clk);
    in_chan.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = val;
    do @(posedge clk); while (!cfg_chan.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  task automatic drain();
    idle_input(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // biased coefficient: near q-1, near a multiple of gamma plus gamma/2, uniform below q, small, or raw
  function automatic word_t pick_coeff();
    longint unsigned q, g, k, v;
    q = (sb.q_reg < 2) ? 2 : sb.q_reg;
    g = (sb.g_reg == 0) ? 1 : sb.g_reg;
    case ($urandom_range(0, 4))
      0: v = q - 1 - $urandom_range(0, 2);
      1: begin
        k = longint'($urandom) % (q / g + 1);
        v = k * g + (g >> 1) + $urandom_range(0, 2) - 1;
      end
      2: v = longint'($urandom) % q;
      3: v = $urandom_range(0, 3);
      default: v = $urandom;
    endcase
    return word_t'(v);
  endfunction

  task automatic random_phase(input int n_items, input bit with_hold);
    int left, burst;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (with_hold) begin
        // long output stall while the whole phase is offered back to back
        hold_off = 300;
        burst = left;
        with_hold = 0;
      end
      repeat (burst) begin
        if (left > 0) begin
          send_request($urandom_range(0, 7) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                       pick_coeff(), pick_coeff());
          left--;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
    end
    drain();
  endtask

  task automatic directed_phase();
    word_t edges[8];
    word_t g;
    g = RST_GAMMA;
    edges = '{32'd0, 32'd1, RST_MODULUS_Q - 1, RST_MODULUS_Q, 32'hFFFF_FFFF,
              g >> 1, (g >> 1) + 1, g};
    foreach (edges[i]) send_request(REQ_DECOMPOSE, edges[i], 32'd0);
    send_request(REQ_MAKE_HINT, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_MAKE_HINT, RST_MODULUS_Q - 1, 32'd1);
    send_request(REQ_MAKE_HINT, g >> 1, 32'd1);
    send_request(REQ_MAKE_HINT, 32'd5, RST_MODULUS_Q - 1);
    send_request(REQ_USE_HINT, RST_MODULUS_Q - 1, 32'd1);
    send_request(REQ_USE_HINT, 32'd0, RST_MODULUS_Q - 1);
    send_request(REQ_USE_HINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(2'd3, 32'd0, 32'd0);
    drain();
  endtask

  task automatic set_regs(input word_t q, input word_t g, input word_t m);
    write_cfg(CFG_MODULUS_Q, q);
    write_cfg(CFG_GAMMA, g);
    write_cfg(CFG_HINT_M, m);
  endtask

  initial begin : stimulus
    word_t q, g;
    sb = new();
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    hold_off = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = '0;
    in_chan.coeff_r = '0;
    in_chan.coeff_other = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    directed_phase();
    random_phase(150, 1);
    set_regs(32'd8380417, 32'd190464, 32'd44);
    random_phase(120, 0);
    set_regs(32'd0, 32'd0, 32'd0);
    random_phase(80, 0);
    set_regs(32'd1, 32'd2, 32'd1);
    random_phase(80, 0);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(100, 0);
    set_regs(32'hFFFF_FFFF, 32'd2, 32'h8000_0000);
    random_phase(100, 1);
    repeat (4) begin
      // small q of the form k*gamma+1 so the wrap-to-zero case is hit often
      g = $urandom_range(2, 300);
      q = g * $urandom_range(1, 40) + 1;
      set_regs(q, g, $urandom_range(1, 50));
      random_phase(90, 0);
    end

    $display("Sent %0d requests, checked %0d results, %0d mismatches", n_sent,
             n_checked, n_errors);
    $display("Covered default, extreme, degenerate and small random q/gamma/m settings");
    if (n_errors == 0 && sb.expected_q.size() == 0)
      $display("PASS lattice_decompose_hint_unit");
    else
      $display("FAIL lattice_decompose_hint_unit");
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
hdl/ldh_pkg.sv
hdl/ldh_if.sv
hdl/ldh_udiv.sv
hdl/ldh_front.sv
hdl/ldh_fifo.sv
hdl/ldh_back.sv
hdl/lattice_decompose_hint_unit.sv
verif/tb.sv
